### hdl/tsd_pkg.sv
// Shared types, constants and fixed-point helpers for the theta-scheme diffusion step core
`default_nettype none
package tsd_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [2:0] {
    REG_LHS_OFF  = 3'd0,
    REG_LHS_DIAG = 3'd1,
    REG_RHS_OFF  = 3'd2,
    REG_RHS_DIAG = 3'd3,
    REG_SPACING  = 3'd4,
    REG_POINTS   = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RHS_RD,
    ST_RHS_MUL,
    ST_RHS_SUM,
    ST_FWD_RD,
    ST_FWD_MUL,
    ST_FWD_DIV,
    ST_FWD_WR,
    ST_BWD_RD,
    ST_BWD_MUL,
    ST_BWD_DIV,
    ST_BWD_WR,
    ST_OUT_RD,
    ST_OUT_EMIT
  } state_e;

  // request / response between sequencer and divider
  typedef struct packed {
    logic                     go;
    logic signed [WORD_W-1:0] num;
    logic signed [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WORD_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WORD_W+1:0] x);
    logic signed [WORD_W+1:0] hi;
    logic signed [WORD_W+1:0] lo;
    hi = (WORD_W+2)'(33'sh0_7FFF_FFFF);
    lo = -hi - (WORD_W+2)'(1);
    if (x > hi) return {1'b0, {(WORD_W-1){1'b1}}};
    else if (x < lo) return {1'b1, {(WORD_W-1){1'b0}}};
    else return x[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] qadd(input logic signed [WORD_W-1:0] a,
                                                    input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W+1:0] s;
    s = (WORD_W+2)'(a) + (WORD_W+2)'(b);
    return sat_word(s);
  endfunction

  function automatic logic signed [WORD_W-1:0] qsub(input logic signed [WORD_W-1:0] a,
                                                    input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W+1:0] s;
    s = (WORD_W+2)'(a) - (WORD_W+2)'(b);
    return sat_word(s);
  endfunction

endpackage
`default_nettype wire

### hdl/tsd_div.sv
// Sequential saturating signed fixed-point divider, one quotient bit per cycle
`default_nettype none
module tsd_div import tsd_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);
  localparam int unsigned NW = WORD_W + FRAC_BITS;        // dividend magnitude width
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]       quo_q, quo_d;
  logic [WORD_W-1:0]   rem_q, rem_d;
  logic [WORD_W-1:0]   den_q, den_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic signed [WORD_W-1:0] res_q, res_d;
  logic [WORD_W:0]     trial;
  logic [WORD_W+1:0]   sres;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0; res_d = res_q;
    trial = '0; sres = '0;
    if (req_i.go) begin
      if (req_i.den == '0) begin
        done_d = 1'b1;
        if (req_i.num > 0)      res_d = {1'b0, {(WORD_W-1){1'b1}}};
        else if (req_i.num < 0) res_d = {1'b1, {(WORD_W-1){1'b0}}};
        else                    res_d = '0;
      end else begin
        busy_d = 1'b1;
        neg_d  = req_i.num[WORD_W-1] ^ req_i.den[WORD_W-1];
        quo_d  = {(req_i.num[WORD_W-1] ? WORD_W'(-req_i.num) : WORD_W'(req_i.num)),
                  {FRAC_BITS{1'b0}}};
        den_d  = req_i.den[WORD_W-1] ? WORD_W'(-req_i.den) : WORD_W'(req_i.den);
        rem_d  = '0;
        cnt_d  = CW'(NW);
      end
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = WORD_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[WORD_W-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        // saturate magnitude then apply sign
        if (quo_d[NW-1:WORD_W+1] != '0) sres = {2'b00, {WORD_W{1'b1}}};
        else                            sres = {1'b0, quo_d[WORD_W:0]};
        if (neg_q) sres = -sres;
        res_d = sat_word($signed(sres));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; neg_q <= neg_d; res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = res_q;
endmodule
`default_nettype wire

### hdl/theta_scheme_diffusion_step_core.sv
// Top level: field memories, step sequencer, fixed-point datapath
//
//  channel | signals                                     | dir | handshake
//  --------+---------------------------------------------+-----+-----------------
//  item    | mode_i point_index_i point_value_i          | in  | start_i & !busy_o
//  config  | cfg_index_i cfg_data_i                      | in  | cfg_valid_i & cfg_ready_o
//  result  | out_index_o out_value_o last_o              | out | out_strobe_o
//
// A load item is written to the field memory straight from idle and never raises busy.
// A step item keeps busy high while it works through the active points: rhs rows,
// forward rows, backward rows and output words, in that order; each division yields
// 48 quotient bits, or none when the divisor is zero. Results cannot be stalled. Reset
// clears control and the field memory valid bits; other memories need no clearing.
`default_nettype none
module theta_scheme_diffusion_step_core import tsd_pkg::*; #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         mode_i,
  input  wire logic [5:0]                   point_index_i,
  input  wire logic signed [WORD_W-1:0]     point_value_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [2:0]                   cfg_index_i,
  input  wire logic [WORD_W-1:0]            cfg_data_i,
  output logic                              out_strobe_o,
  output logic [5:0]                        out_index_o,
  output logic signed [WORD_W-1:0]          out_value_o,
  output logic                              last_o
);
  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW = 2 * WORD_W;

  // configuration
  logic signed [WORD_W-1:0] c_q, d_q, r_q, s_q, h_q;
  logic [6:0]               np_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q  <= '0;
      d_q  <= WORD_W'(1) << (FRAC_BITS + 1);
      r_q  <= '0;
      s_q  <= WORD_W'(1) << (FRAC_BITS + 1);
      h_q  <= '0;
      np_q <= 7'd64;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_LHS_OFF:  c_q  <= cfg_data_i;
        REG_LHS_DIAG: d_q  <= cfg_data_i;
        REG_RHS_OFF:  r_q  <= cfg_data_i;
        REG_RHS_DIAG: s_q  <= cfg_data_i;
        REG_SPACING:  h_q  <= cfg_data_i;
        REG_POINTS:   np_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective point count
  logic [NW-1:0] n_eff;
  always_comb begin
    if (np_q < 7'd4)                 n_eff = NW'(4);
    else if (32'(np_q) > MAX_POINTS) n_eff = NW'(MAX_POINTS);
    else                             n_eff = NW'(np_q);
  end

  // memories: field (valid bits model the zero reset), rhs, pivot, forward
  logic [WORD_W-1:0] fmem [MAX_POINTS];
  logic [WORD_W-1:0] bmem [MAX_POINTS];
  logic [WORD_W-1:0] pmem [MAX_POINTS];
  logic [WORD_W-1:0] gmem [MAX_POINTS];
  logic [MAX_POINTS-1:0] fval_q;

  logic              fwe, bwe, pwe, gwe;
  logic [AW-1:0]     fwa, bwa, pwa, gwa, fra, bra, pra, gra;
  logic [WORD_W-1:0] fwd_w, bwd_w, pwd_w, gwd_w;
  logic [WORD_W-1:0] frd_q, brd_q, prd_q, grd_q;
  logic              frv_q;

  always_ff @(posedge clk_i) begin
    if (fwe) fmem[fwa] <= fwd_w;
    if (bwe) bmem[bwa] <= bwd_w;
    if (pwe) pmem[pwa] <= pwd_w;
    if (gwe) gmem[gwa] <= gwd_w;
    frd_q <= fmem[fra];
    brd_q <= bmem[bra];
    prd_q <= pmem[pra];
    grd_q <= gmem[gra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fval_q <= '0;
      frv_q  <= 1'b0;
    end else begin
      frv_q <= fval_q[fra];
      if (fwe) fval_q[fwa] <= 1'b1;
    end
  end
  wire logic signed [WORD_W-1:0] fld_rd = frv_q ? frd_q : '0;

  // sequencer
  state_e state_q, state_d;
  logic [NW-1:0] i_q, i_d;        // point counter
  logic [1:0]    k_q, k_d;        // sub-step within a point
  logic signed [WORD_W-1:0] a_q, a_d, b_q, b_d, e_q, e_d;
  logic          x_q, x_d;        // divider request issued
  logic signed [WORD_W-1:0] m0_a, m0_b;
  logic signed [PW-1:0]     prod_q;
  logic signed [WORD_W-1:0] qm;
  div_req_t dreq;
  div_rsp_t drsp;
  logic     out_stb_d, out_stb_q;
  logic [5:0] out_idx_q, out_idx_d;
  logic signed [WORD_W-1:0] out_val_q, out_val_d;
  logic     last_q, last_d;

  tsd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp)
  );

  // one registered multiplier, rounded and saturated on its output
  always_ff @(posedge clk_i) prod_q <= PW'(m0_a) * PW'(m0_b);
  always_comb begin
    logic signed [PW+1:0] p;
    logic signed [PW+1:0] sh;
    p  = (PW+2)'(prod_q) + ((PW+2)'(1) <<< (FRAC_BITS - 1));
    sh = p >>> FRAC_BITS;
    if (sh > (PW+2)'(34'sh0_7FFF_FFFF))       qm = {1'b0, {(WORD_W-1){1'b1}}};
    else if (sh < -(PW+2)'(34'sh0_8000_0000)) qm = {1'b1, {(WORD_W-1){1'b0}}};
    else                                      qm = sh[WORD_W-1:0];
  end

  wire logic [NW-1:0] nm1 = n_eff - NW'(1);
  wire logic [NW-1:0] nm2 = n_eff - NW'(2);

  always_comb begin
    state_d = state_q; i_d = i_q; k_d = k_q;
    a_d = a_q; b_d = b_q; e_d = e_q; x_d = x_q;
    fwe = 1'b0; bwe = 1'b0; pwe = 1'b0; gwe = 1'b0;
    fwa = '0; bwa = '0; pwa = '0; gwa = '0;
    fra = '0; bra = '0; pra = '0; gra = '0;
    fwd_w = '0; bwd_w = '0; pwd_w = '0; gwd_w = '0;
    m0_a = '0; m0_b = '0;
    dreq = '0;
    out_stb_d = 1'b0; out_idx_d = out_idx_q; out_val_d = out_val_q; last_d = last_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (!mode_i) begin
            if (32'(point_index_i) < MAX_POINTS) begin
              fwe = 1'b1; fwa = AW'(point_index_i); fwd_w = point_value_i;
            end
          end else begin
            i_d = NW'(1); k_d = '0; state_d = ST_RHS_RD;
          end
        end
      end
      // rhs: b[i] = r*u[i-1] + s*u[i] + r*u[i+1], right neighbour dropped on first and
      // last rows
      ST_RHS_RD: begin
        fra = AW'(i_q + NW'(k_q) - NW'(1));
        state_d = ST_RHS_MUL;
      end
      ST_RHS_MUL: begin
        m0_a = (k_q == 2'd1) ? s_q : r_q;
        m0_b = fld_rd;
        if (k_q == 2'd2 && (i_q == NW'(1) || i_q == nm2)) m0_b = '0;
        state_d = ST_RHS_SUM;
      end
      ST_RHS_SUM: begin
        a_d = (k_q == 2'd0) ? qm : qadd(a_q, qm);
        if (k_q == 2'd2) begin
          bwe = 1'b1; bwa = AW'(i_q); bwd_w = a_d;
          k_d = '0;
          if (i_q == nm2) begin
            i_d = NW'(1); state_d = ST_FWD_RD;
          end else begin
            i_d = i_q + NW'(1); state_d = ST_RHS_RD;
          end
        end else begin
          k_d = k_q + 2'd1; state_d = ST_RHS_RD;
        end
      end
      // forward: k=0 pivot, k=1 rhs term
      ST_FWD_RD: begin
        pra = AW'(i_q - NW'(1)); gra = AW'(i_q - NW'(1)); bra = AW'(i_q);
        if (i_q == NW'(1)) begin
          pwe = 1'b1; pwa = AW'(i_q); pwd_w = d_q;
          state_d = ST_FWD_WR;  // f[1] copied once read data is there
        end else state_d = ST_FWD_MUL;
      end
      ST_FWD_MUL: begin
        m0_a = c_q;
        if (k_q == 2'd0) begin
          // read data only valid now; a keeps f[i-1] for the second pass
          m0_b = c_q;
          e_d = prd_q; b_d = brd_q; a_d = grd_q;
        end else begin
          m0_b = a_q;
        end
        state_d = ST_FWD_DIV;
      end
      ST_FWD_DIV: begin
        if (!x_q) begin
          dreq.go = 1'b1; dreq.num = qm; dreq.den = e_q; x_d = 1'b1;
        end else if (drsp.done) begin
          x_d = 1'b0;
          if (k_q == 2'd0) begin
            pwe = 1'b1; pwa = AW'(i_q); pwd_w = qsub(d_q, drsp.quo);
            k_d = 2'd1; state_d = ST_FWD_MUL;
          end else begin
            gwe = 1'b1; gwa = AW'(i_q); gwd_w = qsub(b_q, drsp.quo);
            k_d = '0; state_d = ST_FWD_WR;
          end
        end
      end
      ST_FWD_WR: begin
        if (i_q == NW'(1)) begin
          gwe = 1'b1; gwa = AW'(1); gwd_w = brd_q;
        end
        if (i_q == nm2) begin
          i_d = nm2; state_d = ST_BWD_RD; a_d = '0;  // a holds u[i+1]
        end else begin
          i_d = i_q + NW'(1); state_d = ST_FWD_RD;
        end
      end
      // backward: u[i] = (f[i] - c*u[i+1]) / p[i]
      ST_BWD_RD: begin
        pra = AW'(i_q); gra = AW'(i_q);
        state_d = ST_BWD_MUL;
      end
      ST_BWD_MUL: begin
        m0_a = c_q; m0_b = a_q;
        e_d = prd_q; b_d = grd_q;
        state_d = ST_BWD_DIV;
      end
      ST_BWD_DIV: begin
        if (!x_q) begin
          dreq.go = 1'b1; dreq.num = (i_q == nm2) ? b_q : qsub(b_q, qm); dreq.den = e_q;
          x_d = 1'b1;
        end else if (drsp.done) begin
          x_d = 1'b0; a_d = drsp.quo; state_d = ST_BWD_WR;
        end
      end
      ST_BWD_WR: begin
        fwe = 1'b1; fwa = AW'(i_q); fwd_w = a_q;
        if (i_q == NW'(1)) begin
          i_d = '0; state_d = ST_OUT_RD;
        end else begin
          i_d = i_q - NW'(1); state_d = ST_BWD_RD;
        end
      end
      ST_OUT_RD: begin
        fra = AW'(i_q);
        if (i_q == '0 || i_q == nm1) begin
          fwe = 1'b1; fwa = AW'(i_q); fwd_w = '0;
        end
        m0_a = h_q; m0_b = WORD_W'(i_q) <<< FRAC_BITS;
        state_d = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        out_stb_d = 1'b1;
        out_idx_d = 6'(i_q);
        out_val_d = qadd((i_q == '0 || i_q == nm1) ? '0 : fld_rd, qm);
        last_d    = (i_q == nm1);
        if (i_q == nm1) state_d = ST_IDLE;
        else begin
          i_d = i_q + NW'(1); state_d = ST_OUT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      i_q       <= '0;
      k_q       <= '0;
      x_q       <= 1'b0;
      out_stb_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      i_q       <= i_d;
      k_q       <= k_d;
      x_q       <= x_d;
      out_stb_q <= out_stb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; e_q <= e_d;
    out_idx_q <= out_idx_d; out_val_q <= out_val_d; last_q <= last_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign out_strobe_o = out_stb_q;
  assign out_index_o  = out_idx_q;
  assign out_value_o  = out_val_q;
  assign last_o       = last_q;
endmodule
`default_nettype wire

### hdl/tsd_checker.sv
// Port-level checker for the diffusion step core, with its bind
`default_nettype none
module tsd_port_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic out_strobe_o,
  input wire logic last_o,
  input wire logic [5:0] out_index_o
);
  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !$past(busy_o)) |-> !out_strobe_o) else $error("word while idle");
  a_busy_needs_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_o && !start_i) |=> !busy_o) else $error("busy without start");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && last_o) |-> !busy_o) else $error("busy on last word");
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_o) |-> ##2 (out_strobe_o && out_index_o == $past(out_index_o, 2) + 6'd1))
    else $error("index not consecutive");
endmodule

bind theta_scheme_diffusion_step_core tsd_port_checker u_tsd_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .out_strobe_o(out_strobe_o), .last_o(last_o), .out_index_o(out_index_o)
);
`default_nettype wire

### sim/tsd_checker.sv
// Checker: predicts step outputs from observed words and compares against the result port
`timescale 1ns / 100ps
`default_nettype none
module tsd_checker import tsd_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_i,
  input  wire logic                     mode_i,
  input  wire logic [5:0]               point_index_i,
  input  wire logic signed [WORD_W-1:0] point_value_i,
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_i,
  input  wire logic [2:0]               cfg_index_i,
  input  wire logic [WORD_W-1:0]        cfg_data_i,
  input  wire logic                     out_strobe_i,
  input  wire logic [5:0]               out_index_i,
  input  wire logic signed [WORD_W-1:0] out_value_i,
  input  wire logic                     last_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  localparam int FRAC = 16;
  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;

  typedef struct packed {
    logic [5:0]               idx;
    logic signed [WORD_W-1:0] val;
    logic                     lst;
  } point_t;

  longint c_coef, d_coef, r_coef, s_coef, spacing;
  int unsigned npts;
  longint field[64];
  longint rhs[64];
  longint piv[64];
  longint fwd[64];
  point_t exp_points[$];

  assign pending_o = exp_points.size();

  function automatic longint sat(input longint x);
    if (x > WMAX) return WMAX;
    if (x < WMIN) return WMIN;
    return x;
  endfunction

  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC - 1));
    return sat(p >>> FRAC);
  endfunction

  function automatic longint fx_div(input longint a, input longint b);
    if (b == 0) return (a > 0) ? WMAX : (a < 0) ? WMIN : 0;
    return sat((a * 65536) / b);
  endfunction

  task automatic diffuse_step();
    int n;
    point_t pt;
    n = (npts < 4) ? 4 : (npts > 64) ? 64 : int'(npts);
    rhs[0] = 0;
    rhs[n-1] = 0;
    rhs[1] = sat(fx_mul(r_coef, field[0]) + fx_mul(s_coef, field[1]));
    for (int i = 2; i <= n - 3; i++)
      rhs[i] = sat(sat(fx_mul(r_coef, field[i-1]) + fx_mul(s_coef, field[i]))
                   + fx_mul(r_coef, field[i+1]));
    rhs[n-2] = sat(fx_mul(r_coef, field[n-3]) + fx_mul(s_coef, field[n-2]));
    piv[1] = d_coef;
    fwd[1] = rhs[1];
    for (int i = 2; i <= n - 2; i++) begin
      piv[i] = sat(d_coef - fx_div(fx_mul(c_coef, c_coef), piv[i-1]));
      fwd[i] = sat(rhs[i] - fx_div(fx_mul(c_coef, fwd[i-1]), piv[i-1]));
    end
    field[0] = 0;
    field[n-1] = 0;
    field[n-2] = fx_div(fwd[n-2], piv[n-2]);
    for (int i = n - 2; i > 1; i--)
      field[i-1] = fx_div(sat(fwd[i-1] - fx_mul(c_coef, field[i])), piv[i-1]);
    for (int i = 0; i < n; i++) begin
      pt.idx = i[5:0];
      pt.val = 32'(sat(field[i] + sat(spacing * i)));
      pt.lst = (i == n - 1);
      exp_points.push_back(pt);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    if (!rst_ni) begin
      c_coef = 0; d_coef = 131072; r_coef = 0; s_coef = 131072; spacing = 0; npts = 64;
      foreach (field[i]) field[i] = 0;
      exp_points.delete();
      fail_count_o <= 0;
    end else begin
      if (out_strobe_i) begin
        if (exp_points.size() == 0) begin
          $error("unexpected result word idx=%0d val=%0d", out_index_i, out_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = exp_points.pop_front();
          if (out_index_i !== e.idx || out_value_i !== e.val || last_i !== e.lst) begin
            if (out_index_i !== e.idx) $error("out_index exp %0d got %0d", e.idx, out_index_i);
            if (out_value_i !== e.val) $error("out_value exp %0d got %0d", e.val, out_value_i);
            if (last_i !== e.lst) $error("last exp %0d got %0d", e.lst, last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_LHS_OFF:  c_coef = longint'($signed(cfg_data_i));
          REG_LHS_DIAG: d_coef = longint'($signed(cfg_data_i));
          REG_RHS_OFF:  r_coef = longint'($signed(cfg_data_i));
          REG_RHS_DIAG: s_coef = longint'($signed(cfg_data_i));
          REG_SPACING:  spacing = longint'($signed(cfg_data_i));
          REG_POINTS:   npts = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        if (mode_i) diffuse_step();
        else field[point_index_i] = longint'(point_value_i);
      end
    end
  end
endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench top: clock, reset, stimulus for the diffusion step core, and verdict
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import tsd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic mode_i = 1'b0;
  logic [5:0] point_index_i = '0;
  logic signed [WORD_W-1:0] point_value_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [WORD_W-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, out_strobe_o, last_o;
  logic [5:0] out_index_o;
  logic signed [WORD_W-1:0] out_value_o;
  int fail_count, pending;
  bit no_idle;

  always #10 clk_i = ~clk_i;

  theta_scheme_diffusion_step_core i_dut (.*);

  tsd_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .mode_i, .point_index_i, .point_value_i,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .out_strobe_i(out_strobe_o), .out_index_i(out_index_o), .out_value_i(out_value_o),
    .last_i(last_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // drive one item word, hold until accepted
  task automatic send_item(input logic m, input logic [5:0] idx, input logic [31:0] v);
    cfg_valid_i <= 1'b0;
    while (!no_idle && $urandom_range(99) < 21) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    mode_i <= m;
    point_index_i <= idx;
    point_value_i <= v;
    // busy is stable at the falling edge, so the word goes in at the next rising edge
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e r, input logic [31:0] v);
    while (!no_idle && $urandom_range(99) < 21) begin
      cfg_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i <= v;
    while (!cfg_ready_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(8 * 65536))) - 32'd4 * 65536;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    #50ms;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // directed: default coefficients, extremes of load fields
    send_item(1'b0, 6'd0, 32'h7FFF_FFFF);
    send_item(1'b0, 6'd63, 32'h8000_0000);
    send_item(1'b0, 6'd1, 32'h0001_0000);
    send_item(1'b0, 6'd62, 32'hFFFF_0000);
    send_item(1'b0, 6'd31, 32'hFFFF_FFFF);
    send_item(1'b1, 6'd0, 32'd0);
    drain();
    // zero diagonal: divisions by zero
    write_reg(REG_LHS_DIAG, 32'd0);
    write_reg(REG_POINTS, 32'd2);
    send_item(1'b0, 6'd1, 32'h0003_0000);
    send_item(1'b0, 6'd2, 32'hFFFD_0000);
    send_item(1'b1, 6'd0, 32'd0);
    drain();
    write_reg(REG_POINTS, 32'd127);
    write_reg(REG_LHS_OFF, 32'h8000_0000);
    write_reg(REG_RHS_OFF, 32'h7FFF_FFFF);
    write_reg(REG_RHS_DIAG, 32'h8000_0000);
    write_reg(REG_SPACING, 32'h7FFF_FFFF);
    send_item(1'b1, 6'd0, 32'd0);
    drain();
    // typical diffusion setup at the minimum size
    write_reg(REG_LHS_OFF, 32'hFFFF_8000);
    write_reg(REG_LHS_DIAG, 32'h0003_0000);
    write_reg(REG_RHS_OFF, 32'h0000_8000);
    write_reg(REG_RHS_DIAG, 32'h0001_0000);
    write_reg(REG_SPACING, 32'h8000_0000);
    write_reg(REG_POINTS, 32'd4);
    send_item(1'b0, 6'd1, 32'h0002_0000);
    send_item(1'b0, 6'd2, 32'h0001_0000);
    send_item(1'b1, 6'd0, 32'd0);
    drain();
    // random phases: new settings, then loads with a step
    for (int ph = 0; ph < 10; ph++) begin
      no_idle = (ph == 4);
      write_reg(REG_LHS_OFF, ($urandom_range(3) == 0) ? rand_val() : -($urandom_range(65536)));
      write_reg(REG_LHS_DIAG, ($urandom_range(3) == 0) ? rand_val() : 32'd131072 + $urandom_range(131072));
      write_reg(REG_RHS_OFF, ($urandom_range(3) == 0) ? rand_val() : $urandom_range(65536));
      write_reg(REG_RHS_DIAG, ($urandom_range(3) == 0) ? rand_val() : $urandom_range(131072));
      write_reg(REG_SPACING, ($urandom_range(3) == 0) ? rand_val() : $urandom_range(4096));
      write_reg(REG_POINTS, (ph == 9) ? 32'd64 : 32'($urandom_range(15)) + 32'd2);
      for (int k = 0; k < 11; k++)
        send_item(1'b0, 6'($urandom()), rand_val());
      send_item(1'b1, 6'($urandom()), $urandom());
      if ($urandom_range(1)) send_item(1'b1, 6'($urandom()), $urandom());
      drain();
    end
    no_idle = 1'b0;
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
hdl/tsd_pkg.sv
hdl/tsd_div.sv
hdl/theta_scheme_diffusion_step_core.sv
hdl/tsd_checker.sv
sim/tsd_checker.sv
sim/testbench.sv
